>>> design/pkc_pkg.sv
package pkc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CFG_IDX_W   = 3;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CFG_WIDTH-1:0]   cfg_word_t;
    typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
    typedef logic [2:0]             event_t;

    localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // event codes
    localparam event_t EV_NONE         = 3'd0;
    localparam event_t EV_PRESS_START  = 3'd1;
    localparam event_t EV_VOLUME_UP    = 3'd2;
    localparam event_t EV_PREV_TRACK   = 3'd3;
    localparam event_t EV_SHORT_IGNORE = 3'd4;
    localparam event_t EV_MID_IGNORE   = 3'd5;
    localparam event_t EV_SAVE_REQ     = 3'd6;
    localparam event_t EV_ARMED        = 3'd7;

    // configuration register indexes
    localparam cfg_idx_t CFG_DEBOUNCE  = 3'd0;
    localparam cfg_idx_t CFG_SAVE_HOLD = 3'd1;
    localparam cfg_idx_t CFG_SHORT_MAX = 3'd2;
    localparam cfg_idx_t CFG_TRACK     = 3'd3;
    localparam cfg_idx_t CFG_ACTIVE    = 3'd4;

    // reset values of the configuration registers
    localparam logic [15:0] DEBOUNCE_RST  = 16'd40;
    localparam logic [15:0] SAVE_HOLD_RST = 16'd1000;
    localparam logic [15:0] SHORT_MAX_RST = 16'd500;

    function automatic count_t sat_inc(input count_t v);
        count_t r;
        r = (v == COUNT_MAX) ? v : v + count_t'(1);
        return r;
    endfunction

endpackage

>>> design/pkc_in_if.sv
interface pkc_in_if;
    logic valid;
    logic ready;
    logic key_level;
    logic media_in_front;

    modport source (output valid, output key_level, output media_in_front, input ready);
    modport sink   (input valid, input key_level, input media_in_front, output ready);
endinterface

>>> design/pkc_out_if.sv
interface pkc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic       key_pressed;
    logic       is_armed;

    modport source (output valid, output event_res, output key_pressed, output is_armed,
                    input ready);
    modport sink   (input valid, input event_res, input key_pressed, input is_armed,
                    output ready);
endinterface

>>> design/power_key_press_classifier_unit.sv
// channel   dir  payload                         transfer when
// tick      in   key_level, media_in_front       tick.valid && tick.ready
// result    out  event_res, key_pressed, is_armed result.valid && result.ready
// cfg       in   cfg_index, cfg_wdata            cfg_we high at clock edge
//
// a tick goes into the input stage, then the update logic loads the result
// register; one tick per cycle sustained while results are taken
// the input stage refills in the cycle it drains, so a held result only stops
// the flow once both the input stage and the result register are full
// rst_n clears control state and loads the default configuration
// exactly one result transfer for every tick transfer
module power_key_press_classifier_unit
(
    input  logic               clk,
    input  logic               rst_n,
    pkc_in_if.sink             tick,
    pkc_out_if.source          result,
    input  logic               cfg_we,
    input  pkc_pkg::cfg_idx_t  cfg_index,
    input  pkc_pkg::cfg_word_t cfg_wdata
);
    import pkc_pkg::*;

    // configuration
    count_t debounce_reg;
    count_t save_hold_reg;
    count_t short_max_reg;
    logic   track_mode_reg;
    logic   active_level_reg;

    // input stage
    logic   in_valid_reg;
    logic   key_reg;
    logic   media_reg;

    // tick state
    logic   started_reg,   started_next;
    logic   raw_reg,       raw_next;
    logic   stable_reg,    stable_next;
    logic   armed_reg,     armed_next;
    logic   timing_reg,    timing_next;
    logic   save_done_reg, save_done_next;
    count_t since_reg,     since_next;
    count_t hold_reg,      hold_next;
    event_t event_next;

    // result register
    logic   out_valid_reg;
    event_t event_reg;
    logic   key_pressed_reg;
    logic   is_armed_reg;

    logic   out_free;
    logic   advance;
    logic   now_pressed;
    logic   save_check;

    assign out_free = !out_valid_reg || result.ready;
    assign advance  = in_valid_reg && out_free;
    assign tick.ready = !in_valid_reg || out_free;

    assign result.valid       = out_valid_reg;
    assign result.event_res   = event_reg;
    assign result.key_pressed = key_pressed_reg;
    assign result.is_armed    = is_armed_reg;

    // configuration writes, taken any time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= count_t'(DEBOUNCE_RST);
            save_hold_reg    <= count_t'(SAVE_HOLD_RST);
            short_max_reg    <= count_t'(SHORT_MAX_RST);
            track_mode_reg   <= 1'b0;
            active_level_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE:  debounce_reg     <= count_t'(cfg_wdata);
                CFG_SAVE_HOLD: save_hold_reg    <= count_t'(cfg_wdata);
                CFG_SHORT_MAX: short_max_reg    <= count_t'(cfg_wdata);
                CFG_TRACK:     track_mode_reg   <= cfg_wdata[0];
                CFG_ACTIVE:    active_level_reg <= cfg_wdata[0];
                default:       ;
            endcase
        end
    end

    // pressed when the pin matches the active level
    assign now_pressed = (key_reg == active_level_reg);

    always_comb
    begin
        started_next   = started_reg;
        raw_next       = raw_reg;
        stable_next    = stable_reg;
        armed_next     = armed_reg;
        timing_next    = timing_reg;
        save_done_next = save_done_reg;
        since_next     = sat_inc(since_reg);
        hold_next      = timing_reg ? sat_inc(hold_reg) : hold_reg;
        event_next     = EV_NONE;
        save_check     = 1'b0;

        if (!started_reg)
        begin
            // first tick samples the level and arms at once if the key is not pressed
            raw_next       = now_pressed;
            stable_next    = now_pressed;
            since_next     = '0;
            hold_next      = '0;
            timing_next    = 1'b0;
            save_done_next = 1'b0;
            armed_next     = !now_pressed;
            started_next   = 1'b1;
            event_next     = now_pressed ? EV_NONE : EV_ARMED;
        end
        else if (now_pressed != raw_reg)
        begin
            // raw edge restarts the debounce window
            raw_next   = now_pressed;
            since_next = '0;
        end
        else if (now_pressed != stable_reg)
        begin
            if (since_next >= debounce_reg)
            begin
                stable_next = now_pressed;
                if (!now_pressed)
                begin
                    // release accepted
                    if (!armed_reg)
                    begin
                        armed_next = 1'b1;
                        event_next = EV_ARMED;
                    end
                    else if (timing_reg && !save_done_reg)
                    begin
                        if (hold_next <= short_max_reg)
                        begin
                            if (track_mode_reg)
                                event_next = media_reg ? EV_PREV_TRACK : EV_SHORT_IGNORE;
                            else
                                event_next = EV_VOLUME_UP;
                        end
                        else
                        begin
                            event_next = EV_MID_IGNORE;
                        end
                    end
                    timing_next    = 1'b0;
                    save_done_next = 1'b0;
                    hold_next      = '0;
                end
                else if (armed_reg)
                begin
                    // press accepted: start timing the hold
                    timing_next    = 1'b1;
                    hold_next      = '0;
                    save_done_next = 1'b0;
                    event_next     = EV_PRESS_START;
                    save_check     = 1'b1;
                end
            end
        end
        else
        begin
            save_check = 1'b1;
        end

        // one save request per press; zero save hold fires on the press tick
        if (save_check && armed_reg && stable_next && !save_done_next && timing_next
            && hold_next >= save_hold_reg)
        begin
            save_done_next = 1'b1;
            event_next     = EV_SAVE_REQ;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            raw_reg       <= 1'b0;
            stable_reg    <= 1'b0;
            armed_reg     <= 1'b0;
            timing_reg    <= 1'b0;
            save_done_reg <= 1'b0;
            since_reg     <= '0;
            hold_reg      <= '0;
        end
        else
        begin
            if (tick.ready)
                in_valid_reg <= tick.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (advance)
            begin
                started_reg   <= started_next;
                raw_reg       <= raw_next;
                stable_reg    <= stable_next;
                armed_reg     <= armed_next;
                timing_reg    <= timing_next;
                save_done_reg <= save_done_next;
                since_reg     <= since_next;
                hold_reg      <= hold_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            key_reg   <= tick.key_level;
            media_reg <= tick.media_in_front;
        end
        if (advance)
        begin
            event_reg       <= event_next;
            key_pressed_reg <= stable_next;
            is_armed_reg    <= armed_next;
        end
    end

    // once armed the block stays armed
    a_armed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |=> armed_reg)
        else $error("armed state dropped");

    // a save request only belongs to a timed hold
    a_save_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        save_done_reg |-> timing_reg)
        else $error("save flag set outside a timed hold");

    // the hold counter only moves while a hold is timed
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_reg != '0) |-> timing_reg)
        else $error("hold count nonzero with no hold timed");

    // a save request is reported only for an armed, pressed key
    a_save_event: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && event_reg == EV_SAVE_REQ) |-> (key_pressed_reg && is_armed_reg))
        else $error("save request without armed press");

endmodule
